/* rtl/ita_pkg.sv */
// Shared types, sizes and character codes for the integer-to-ASCII converter.
// Used by every module under rtl; depends on nothing else.
package ita_pkg;

  localparam int VALUE_WIDTH = 32;

  // Decimal digits that cover any value below 2^VALUE_WIDTH.
  localparam int NDEC      = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NHEX      = (VALUE_WIDTH + 3) / 4;
  localparam int HEX_BITS  = 4 * NHEX;
  localparam int DIG_BITS  = 4 * NDEC;
  localparam int CNT_W     = $clog2(DIG_BITS + 1);
  localparam int BITCNT_W  = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_UPPER = 7'h41;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_B     = 7'h62;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [1:0]                    radix_code;
  } num_req_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } chr_req_t;

  // Everything the character sequencer needs to start one item.
  typedef struct packed {
    logic                neg;
    logic [1:0]          radix;
    logic [DIG_BITS-1:0] digs;
    logic [CNT_W-1:0]    cnt;
  } emit_load_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {3'b000, d};
    end else begin
      ch = CH_UPPER + {3'b000, d} - 7'd10;
    end
    return ch;
  endfunction

endpackage

/* rtl/ita_dabble.sv */
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit a cycle.
// Depends on ita_pkg for widths.
module ita_dabble (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ita_pkg::VALUE_WIDTH-1:0]   mag,
  output logic                              active,
  output logic                              done,
  output logic [ita_pkg::DIG_BITS-1:0]      bcd
);
  import ita_pkg::*;

  logic                   busy;
  logic [BITCNT_W-1:0]    bitcnt;
  logic [VALUE_WIDTH-1:0] sh;
  logic [DIG_BITS-1:0]    adj;

  // Add 3 to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      bitcnt <= '0;
    end else begin
      done <= busy && (bitcnt == BITCNT_W'(1));
      if (start) begin
        busy   <= 1'b1;
        bitcnt <= BITCNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        bitcnt <= bitcnt - BITCNT_W'(1);
        if (bitcnt == BITCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {adj[DIG_BITS-2:0], sh[VALUE_WIDTH-1]};
    end
  end

  assign active = busy || done;

`ifndef SYNTH
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start |=> (busy && bitcnt == BITCNT_W'(VALUE_WIDTH)))
    else $error("converter did not load a full bit count");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && !$past(done)))
    else $error("conversion done is not a single pulse after the last bit");
`endif

endmodule

/* rtl/ita_emit.sv */
// Character sequencer: sign, radix prefix and digits, one per unstalled cycle,
// into an output register. Digits shift out MSD first. Depends on ita_pkg.
module ita_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ita_pkg::emit_load_t  load_req,
  output logic                 busy,
  output logic                 chr_valid,
  input  logic                 chr_stall,
  output ita_pkg::chr_req_t    chr
);
  import ita_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_LETTER = 3'd4;
  localparam logic [2:0] PH_DIGIT  = 3'd5;

  logic [2:0]          phase;
  logic [2:0]          phase_next;
  logic                neg;
  logic [1:0]          radix;
  logic [DIG_BITS-1:0] digs;
  logic [CNT_W-1:0]    cnt;

  logic       is_bin;
  logic       prefixed;
  logic       top_zero;
  logic [6:0] cur_char;
  logic       cur_last;
  logic       emitting;
  logic       fire;
  logic       shift;

  assign is_bin   = (radix == RADIX_BIN);
  assign prefixed = (radix == RADIX_HEX) || is_bin;
  assign top_zero = is_bin ? !digs[DIG_BITS-1] : (digs[DIG_BITS-1 -: 4] == 4'd0);
  assign emitting = (phase == PH_SIGN) || (phase == PH_ZERO) ||
                    (phase == PH_LETTER) || (phase == PH_DIGIT);
  assign fire     = emitting && (!chr_valid || !chr_stall);

  always_comb begin
    phase_next = phase;
    cur_char   = CH_ZERO;
    cur_last   = 1'b0;
    shift      = 1'b0;
    case (phase)
      PH_IDLE: begin
        phase_next = PH_IDLE;
      end
      PH_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_zero && cnt > CNT_W'(1)) begin
          shift = 1'b1;
        end else if (neg) begin
          phase_next = PH_SIGN;
        end else if (prefixed) begin
          phase_next = PH_ZERO;
        end else begin
          phase_next = PH_DIGIT;
        end
      end
      PH_SIGN: begin
        cur_char = CH_MINUS;
        if (fire) begin
          phase_next = prefixed ? PH_ZERO : PH_DIGIT;
        end
      end
      PH_ZERO: begin
        cur_char = CH_ZERO;
        if (fire) begin
          phase_next = PH_LETTER;
        end
      end
      PH_LETTER: begin
        cur_char = is_bin ? CH_B : CH_X;
        if (fire) begin
          phase_next = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        cur_char = is_bin ? (CH_ZERO + {6'b000000, digs[DIG_BITS-1]})
                          : digit_char(digs[DIG_BITS-1 -: 4]);
        cur_last = (cnt == CNT_W'(1));
        if (fire) begin
          shift = 1'b1;
          if (cnt == CNT_W'(1)) begin
            phase_next = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      chr_valid <= 1'b0;
    end else begin
      if (load) begin
        phase <= PH_SKIP;
      end else begin
        phase <= phase_next;
      end
      if (fire) begin
        chr_valid <= 1'b1;
      end else if (!chr_stall) begin
        chr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg   <= load_req.neg;
      radix <= load_req.radix;
      digs  <= load_req.digs;
      cnt   <= load_req.cnt;
    end else if (shift) begin
      digs <= is_bin ? {digs[DIG_BITS-2:0], 1'b0} : {digs[DIG_BITS-5:0], 4'b0000};
      cnt  <= cnt - CNT_W'(1);
    end
    if (fire) begin
      chr.out_char  <= cur_char;
      chr.last_char <= cur_last;
    end
  end

  assign busy = (phase != PH_IDLE);

`ifndef SYNTH
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && cur_last) |=> (phase == PH_IDLE))
    else $error("sequencer kept running after the final character");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (cnt != '0))
    else $error("digit count ran out while an item was in flight");
`endif

endmodule

/* rtl/integer_to_ascii_radix.sv */
// Converts a signed integer to ASCII text in decimal, "0x" hex (upper case) or
// "0b" binary, one character per output request, most significant first, with a
// leading '-' for negative values and last_char set on the final character. One
// value is in flight at a time: num_stall stays high from acceptance until the
// last character has entered the output register. Hex and binary load the
// sequencer directly; decimal first runs a bit-serial BCD conversion and then
// hands its digits over. The sequencer drops leading zero digits and sends the
// rest, so every digit slot is either dropped or sent; output stalls lengthen
// the time the input is held. Depends on ita_pkg, ita_dabble, ita_emit.
module integer_to_ascii_radix (
  input  logic              clk,
  input  logic              rst,
  input  logic              num_valid,
  output logic              num_stall,
  input  ita_pkg::num_req_t num,
  output logic              chr_valid,
  input  logic              chr_stall,
  output ita_pkg::chr_req_t chr
);
  import ita_pkg::*;

  logic                   accept;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag;
  logic [1:0]             radix_in;
  logic                   neg;
  logic                   dab_start;
  logic                   dab_active;
  logic                   dab_done;
  logic [DIG_BITS-1:0]    bcd;
  logic                   emit_load;
  logic                   emit_busy;
  emit_load_t             load_req;

  assign num_stall = dab_active || emit_busy;
  assign accept    = num_valid && !num_stall;

  assign neg_in = num.value[VALUE_WIDTH-1];
  // Unsigned magnitude, so the most negative value comes out exact.
  assign mag    = neg_in ? (~num.value + VALUE_WIDTH'(1)) : num.value;

  always_comb begin
    case (num.radix_code)
      RADIX_HEX: radix_in = RADIX_HEX;
      RADIX_BIN: radix_in = RADIX_BIN;
      default:   radix_in = RADIX_DEC;
    endcase
  end

  assign dab_start = accept && (radix_in == RADIX_DEC);
  assign emit_load = dab_done || (accept && (radix_in != RADIX_DEC));

  // hold the sign while the BCD conversion runs
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= neg_in;
    end
  end

  always_comb begin
    if (dab_done) begin
      load_req.neg   = neg;
      load_req.radix = RADIX_DEC;
      load_req.digs  = bcd;
      load_req.cnt   = CNT_W'(NDEC);
    end else if (radix_in == RADIX_BIN) begin
      load_req.neg   = neg_in;
      load_req.radix = RADIX_BIN;
      load_req.digs  = DIG_BITS'(mag) << (DIG_BITS - VALUE_WIDTH);
      load_req.cnt   = CNT_W'(VALUE_WIDTH);
    end else begin
      load_req.neg   = neg_in;
      load_req.radix = RADIX_HEX;
      load_req.digs  = DIG_BITS'(mag) << (DIG_BITS - HEX_BITS);
      load_req.cnt   = CNT_W'(NHEX);
    end
  end

  ita_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .start  (dab_start),
    .mag    (mag),
    .active (dab_active),
    .done   (dab_done),
    .bcd    (bcd)
  );

  ita_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_load),
    .load_req  (load_req),
    .busy      (emit_busy),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

`ifndef SYNTH
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(dab_active && emit_busy))
    else $error("converter and sequencer both hold an item");
`endif

endmodule

/* tb/sv/integer_to_ascii_radix_tb.sv */
// Self-checking bench for integer_to_ascii_radix: directed rows, then random values
// and radix codes under bursty input and a stalling receiver, checked per character.
// Depends on ita_pkg and the integer_to_ascii_radix RTL.
module integer_to_ascii_radix_tb;
  import ita_pkg::*;

  localparam logic [1:0] RADIX_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 234;

  typedef struct {
    logic [VALUE_WIDTH-1:0] value;
    logic [1:0]             radix;
    string                  text;  // empty: take the text from predict_text
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     num_valid = 1'b0;
  logic     num_stall;
  num_req_t num = '0;
  logic     chr_valid;
  logic     chr_stall = 1'b0;
  chr_req_t chr;

  chr_req_t expected_chars[$];
  int       error_count = 0;
  logic     hold_on = 1'b0;
  event     long_hold_ev;

  int       rx_mode = 0;
  int       rx_mode_left = 0;
  int       rx_phase = 0;

  dir_row_t dir_rows [22] = '{
    '{32'd0,          RADIX_DEC,   "0"},
    '{32'd0,          RADIX_HEX,   "0x0"},
    '{32'd0,          RADIX_BIN,   "0b0"},
    '{32'd0,          RADIX_SPARE, "0"},
    '{32'h7FFF_FFFF,  RADIX_DEC,   "2147483647"},
    '{32'h8000_0000,  RADIX_DEC,   "-2147483648"},
    '{32'h7FFF_FFFF,  RADIX_HEX,   "0x7FFFFFFF"},
    '{32'h8000_0000,  RADIX_HEX,   "-0x80000000"},
    '{32'h7FFF_FFFF,  RADIX_BIN,   ""},
    '{32'h8000_0000,  RADIX_BIN,   ""},
    '{32'hFFFF_FFFF,  RADIX_DEC,   "-1"},
    '{32'hFFFF_FFFF,  RADIX_HEX,   "-0x1"},
    '{32'hFFFF_FFFF,  RADIX_BIN,   "-0b1"},
    '{-32'sd31,       RADIX_HEX,   "-0x1F"},
    '{32'd255,        RADIX_HEX,   "0xFF"},
    '{32'h00AB_CDEF,  RADIX_HEX,   "0xABCDEF"},
    '{32'd5,          RADIX_BIN,   "0b101"},
    '{32'd9,          RADIX_DEC,   "9"},
    '{32'd10,         RADIX_DEC,   "10"},
    '{32'd1000000000, RADIX_DEC,   "1000000000"},
    '{32'h8000_0000,  RADIX_SPARE, "-2147483648"},
    '{32'h5A5A_A5A5,  RADIX_SPARE, ""}
  };

  integer_to_ascii_radix u_top (
    .clk       (clk),
    .rst       (rst),
    .num_valid (num_valid),
    .num_stall (num_stall),
    .num       (num),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Queue the characters of a literal string, last one flagged.
  function automatic void queue_text(input string s);
    chr_req_t c;
    byte      b;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      c.out_char  = b[6:0];
      c.last_char = (i == s.len() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Work out the text of one request: sign, prefix, then digits of the magnitude.
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value,
                                       input logic [1:0] radix);
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] rem;
    logic [6:0]             digs[$];
    logic [6:0]             text[$];
    int unsigned            base;
    logic [6:0]             letter;
    chr_req_t               c;
    mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
    case (radix)
      RADIX_HEX: begin
        base = 16;
        letter = CH_X;
      end
      RADIX_BIN: begin
        base = 2;
        letter = CH_B;
      end
      default: begin
        base = 10;
        letter = 7'd0;
      end
    endcase
    do begin
      rem = mag % base;
      digs.push_front(rem < 10 ? CH_ZERO + rem[6:0] : CH_UPPER + rem[6:0] - 7'd10);
      mag = mag / base;
    end while (mag != 0);
    if (value[VALUE_WIDTH-1]) text.push_back(CH_MINUS);
    if (letter != 7'd0) begin
      text.push_back(CH_ZERO);
      text.push_back(letter);
    end
    foreach (digs[i]) text.push_back(digs[i]);
    foreach (text[i]) begin
      c.out_char  = text[i];
      c.last_char = (i == text.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Offer one request and hold it until accepted; valid stays high afterward.
  task automatic send_num(input logic [VALUE_WIDTH-1:0] value, input logic [1:0] radix,
                          input string text);
    num_req_t r;
    r.value      = value;
    r.radix_code = radix;
    num       <= r;
    num_valid <= 1'b1;
    do @(posedge clk); while (num_stall);
    if (text.len() != 0) queue_text(text);
    else predict_text(value, radix);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      num_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic logic [VALUE_WIDTH-1:0] random_value();
    logic [VALUE_WIDTH-1:0] v;
    int                     sh;
    v = $urandom;
    sh = $urandom_range(0, VALUE_WIDTH - 1);
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40) - 20;
      1: v = {VALUE_WIDTH{1'b0}} | 1'b1 << sh;
      2: v = -({VALUE_WIDTH{1'b0}} | 1'b1 << sh);
      3: begin
        // powers of ten and neighbors stress decimal carries
        v = 1;
        repeat ($urandom_range(0, 9)) v = v * 10;
        v = v + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: v = $signed(v) >>> sh;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] random_radix();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return RADIX_DEC;
    if (pick < 6) return RADIX_HEX;
    if (pick < 9) return RADIX_BIN;
    return RADIX_SPARE;
  endfunction

  // Receiver: check every accepted character, then pick the next stall value.
  always @(posedge clk) begin
    chr_req_t want;
    if (!rst && chr_valid && !chr_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b", chr.out_char, chr.last_char));
      end else begin
        want = expected_chars.pop_front();
        if (chr.out_char !== want.out_char)
          report_mismatch($sformatf("out_char %h, want %h", chr.out_char, want.out_char));
        if (chr.last_char !== want.last_char)
          report_mismatch($sformatf("last_char %b, want %b (char %h)",
                                    chr.last_char, want.last_char, want.out_char));
      end
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    rx_phase++;
    case (rx_mode)
      0: chr_stall <= hold_on;
      1: chr_stall <= hold_on || ($urandom_range(0, 3) == 0);
      2: chr_stall <= hold_on || ($urandom_range(0, 9) < 7);
      default: chr_stall <= hold_on || rx_phase[0];
    endcase
  end

  // Long receiver hold-off, counted here.
  initial begin
    forever begin
      @(long_hold_ev);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_num(dir_rows[i].value, dir_rows[i].radix, dir_rows[i].text);
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    end

    // Fill the block behind a stalled receiver.
    -> long_hold_ev;
    for (int i = 0; i < 6; i++) send_num(random_value(), random_radix(), "");
    idle_gap(1);
    while (expected_chars.size() != 0) @(posedge clk);
    idle_gap($urandom_range(1, 10));

    for (int n = 0; n < RANDOM_ITEMS; ) begin
      int burst;
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && n < RANDOM_ITEMS; i++, n++)
        send_num(random_value(), random_radix(), "");
      if (n == RANDOM_ITEMS / 2) begin
        // drain fully before going on
        idle_gap(1);
        while (expected_chars.size() != 0) @(posedge clk);
      end
      case ($urandom_range(0, 3))
        0: ;
        1: idle_gap($urandom_range(1, 3));
        2: idle_gap($urandom_range(1, 40));
        default: idle_gap($urandom_range(1, 8));
      endcase
    end

    num_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("integer_to_ascii_radix regression: pass");
    end else begin
      $display("integer_to_ascii_radix regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[%0t] timeout, %0d chars still due", $time, expected_chars.size());
    $display("integer_to_ascii_radix regression: fail");
    $finish;
  end

endmodule
